/* sv/smc_pkg.sv */
// Shared types, constants and the sign table of the sedenion multiplier.
// No dependencies; compiled first.
package smc_pkg;

    localparam int NUM_COMP      = 16;
    localparam int IDX_BITS      = 4;
    localparam int DEF_WORD_BITS = 32;
    localparam int DEF_FRAC_BITS = 16;

    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(NUM_COMP - 1);

    // Row i, bit j set: the term a_i * b_j enters with a minus sign.
    localparam logic [NUM_COMP-1:0] SIGN_NEG [NUM_COMP] = '{
        16'h0000, 16'h966A, 16'hACC6, 16'hDAAC,
        16'h781E, 16'hB274, 16'h4ED8, 16'hE4B2,
        16'h01FE, 16'h9794, 16'hAD38, 16'h5BEA,
        16'h75C4, 16'hEB4A, 16'hC726, 16'h9D50
    };

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } ctl_state_t;

    typedef struct packed {
        logic                load_we;
        logic [IDX_BITS-1:0] load_addr;
        logic                rd_en;
        logic [IDX_BITS-1:0] rd_left_addr;
        logic [IDX_BITS-1:0] rd_right_addr;
        logic                negate;
        logic                first;
        logic                emit;
        logic [IDX_BITS-1:0] emit_index;
    } ctl_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } dp_status_t;

endpackage

/* sv/smc_operand_if.sv */
// Operand channel: valid/ready handshake carrying one pair of components.
// Width follows WORD_BITS.
interface smc_operand_if #(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] a_value;
    logic signed [WORD_BITS-1:0] b_value;

    modport source (output valid, output a_value, output b_value, input ready);
    modport sink   (input valid, input a_value, input b_value, output ready);
endinterface

/* sv/smc_product_if.sv */
// Product channel: valid/ready handshake carrying one product component.
// Width follows WORD_BITS.
interface smc_product_if #(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] product_value;
    logic [3:0]                  component_index;
    logic                        saturated;
    logic                        last;

    modport source (
        output valid, output product_value, output component_index,
        output saturated, output last, input ready
    );
    modport sink (
        input valid, input product_value, input component_index,
        input saturated, input last, output ready
    );
endinterface

/* sv/smc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* sv/smc_controller.sv */
// Sequencer: load phase, per-component issue of 16 multiply-accumulates,
// pipeline drain and result hand-off. Depends on smc_pkg.
module smc_controller
    import smc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);
    ctl_state_t          state_reg, state_next;
    logic [IDX_BITS-1:0] load_cnt_reg, load_cnt_next;
    logic [IDX_BITS-1:0] i_reg, i_next;
    logic [IDX_BITS-1:0] k_reg, k_next;
    logic [IDX_BITS-1:0] j_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            i_reg        <= '0;
            k_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            i_reg        <= i_next;
            k_reg        <= k_next;
        end
    end

    assign j_idx = i_reg ^ k_reg;

    always_comb
    begin
        state_next        = state_reg;
        load_cnt_next     = load_cnt_reg;
        i_next            = i_reg;
        k_next            = k_reg;
        in_ready          = 1'b0;
        cmd               = '0;
        cmd.load_addr     = load_cnt_reg;
        cmd.rd_left_addr  = i_reg;
        cmd.rd_right_addr = j_idx;
        cmd.negate        = SIGN_NEG[i_reg][j_idx];
        cmd.first         = (i_reg == '0);
        cmd.emit_index    = k_reg;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_we   = 1'b1;
                    load_cnt_next = load_cnt_reg + IDX_BITS'(1);
                    if (load_cnt_reg == LAST_IDX)
                    begin
                        i_next     = '0;
                        k_next     = '0;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE:
            begin
                cmd.rd_en = 1'b1;
                i_next    = i_reg + IDX_BITS'(1);
                if (i_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    k_next   = k_reg + IDX_BITS'(1);
                    if (k_reg == LAST_IDX)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Products are only formed on a freshly completed operand set.
    a_issue_after_full_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE) |-> (load_cnt_reg == '0))
        else $error("issue with partial operand set");

    a_last_emit_reloads: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.emit_index == LAST_IDX) |=> (state_reg == ST_LOAD))
        else $error("no return to load after last component");

    a_load_starts_clean: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> (load_cnt_reg == '0 && k_reg == '0))
        else $error("load phase entered with stale counters");
endmodule

/* sv/smc_datapath.sv */
// Operand stores, multiply-accumulate pipeline, round/saturate and the
// output word register. Depends on smc_pkg, smc_ram, smc_product_if.
module smc_datapath
    import smc_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic signed [WORD_BITS-1:0] a_value,
    input  logic signed [WORD_BITS-1:0] b_value,
    input  ctl_cmd_t                    cmd,
    output dp_status_t                  status,
    smc_product_if.source               product
);
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int ACC_BITS  = PROD_BITS + IDX_BITS;

    logic [WORD_BITS-1:0]        left_q, right_q;
    logic                        v1_reg, neg1_reg, first1_reg;
    logic                        v2_reg, neg2_reg, first2_reg;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [ACC_BITS-1:0]  acc_reg, acc_next, term, acc_base;
    logic signed [ACC_BITS-1:0]  shifted;
    logic [ACC_BITS-WORD_BITS:0] upper;
    logic                        fits;
    logic [WORD_BITS-1:0]        result;

    logic                        out_valid_reg;
    logic [WORD_BITS-1:0]        out_value_reg;
    logic [IDX_BITS-1:0]         out_index_reg;
    logic                        out_sat_reg;
    logic                        out_last_reg;

    smc_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_COMP)) u_left_ram (
        .clk   (clk),
        .we    (cmd.load_we),
        .waddr (cmd.load_addr),
        .wdata (a_value),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_left_addr),
        .rdata (left_q)
    );

    smc_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_COMP)) u_right_ram (
        .clk   (clk),
        .we    (cmd.load_we),
        .waddr (cmd.load_addr),
        .wdata (b_value),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_right_addr),
        .rdata (right_q)
    );

    // stage tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        neg1_reg   <= cmd.negate;
        first1_reg <= cmd.first;
        neg2_reg   <= neg1_reg;
        first2_reg <= first1_reg;
        prod_reg   <= $signed(left_q) * $signed(right_q);
        if (v2_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    always_comb
    begin
        term     = ACC_BITS'(prod_reg);
        acc_base = first2_reg ? '0 : acc_reg;
        if (neg2_reg)
        begin
            acc_next = acc_base - term;
        end
        else
        begin
            acc_next = acc_base + term;
        end
    end

    // floor shift, then clamp when the upper bits are not pure sign
    assign shifted = acc_reg >>> FRAC_BITS;
    assign upper   = shifted[ACC_BITS-1:WORD_BITS-1];
    assign fits    = (&upper) || !(|upper);

    always_comb
    begin
        if (fits)
        begin
            result = shifted[WORD_BITS-1:0];
        end
        else if (acc_reg[ACC_BITS-1])
        begin
            result = {1'b1, {(WORD_BITS-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(WORD_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (product.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_value_reg <= result;
            out_index_reg <= cmd.emit_index;
            out_sat_reg   <= !fits;
            out_last_reg  <= (cmd.emit_index == LAST_IDX);
        end
    end

    assign status.pipe_busy = v1_reg || v2_reg;
    assign status.out_free  = !out_valid_reg || product.ready;

    assign product.valid           = out_valid_reg;
    assign product.product_value   = out_value_reg;
    assign product.component_index = out_index_reg;
    assign product.saturated       = out_sat_reg;
    assign product.last            = out_last_reg;

    a_emit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!v1_reg && !v2_reg))
        else $error("word emitted before accumulation finished");

    a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || product.ready))
        else $error("pending output word overwritten");

    a_sat_is_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_sat_reg) |->
            (out_value_reg == {1'b1, {(WORD_BITS-1){1'b0}}} ||
             out_value_reg == {1'b0, {(WORD_BITS-1){1'b1}}}))
        else $error("saturated word not clamped");
endmodule

/* sv/sedenion_multiplier_core.sv */
// Top level of the sedenion multiplier: controller plus datapath.
// Depends on smc_pkg, smc_operand_if, smc_product_if, smc_controller, smc_datapath.
//
//  channel   dir  handshake     word contents
//  operand   in   valid/ready   a_value, b_value (signed, WORD_BITS each)
//  product   out  valid/ready   product_value, component_index, saturated, last
//
// Sixteen operand words are taken one per cycle; the product is then computed
// by one shared multiply-accumulate unit, which issues the 16 terms of each
// component, waits for the pipeline to drain and hands the word off.
// The operand channel is not ready while the product is being computed.
// A stalled product word holds the sequencer in its hand-off step; nothing
// is dropped. Reset clears the load counter and all valid flags; the operand
// stores are not cleared since they are always written before being read.
module sedenion_multiplier_core
    import smc_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    smc_operand_if.sink   operand,
    smc_product_if.source product
);
    ctl_cmd_t   cmd;
    dp_status_t status;
    logic       ctl_in_ready;

    // controller owns the operand handshake
    smc_controller u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (operand.valid),
        .in_ready (ctl_in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    assign operand.ready = ctl_in_ready;

    // stores, MAC pipeline and output word register
    smc_datapath #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .a_value (operand.a_value),
        .b_value (operand.b_value),
        .cmd     (cmd),
        .status  (status),
        .product (product)
    );
endmodule
